@@ sv/prt_pkg.sv @@
`timescale 1ns / 1ps
package prt_pkg;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_REL   = 2'd1,
    KIND_REPLY = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  localparam logic signed [31:0] NO_CLOCK = -32'sd1;

endpackage

@@ sv/prt_in_if.sv @@
`timescale 1ns / 1ps
interface prt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  tbl_id;
  logic [19:0] row_id;
  logic [30:0] clock_req;
  logic [7:0]  thread_id;

  modport source (output valid, cmd, tbl_id, row_id, clock_req, thread_id, input ready);
  modport sink (input valid, cmd, tbl_id, row_id, clock_req, thread_id, output ready);
endinterface

@@ sv/prt_out_if.sv @@
`timescale 1ns / 1ps
interface prt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [7:0]         released_thread;
  logic               send_now;
  logic signed [31:0] req_clock;
  logic               last;

  modport source (output valid, result_kind, released_thread, send_now, req_clock,
                  last, input ready);
  modport sink (input valid, result_kind, released_thread, send_now, req_clock,
                last, output ready);
endinterface

@@ sv/pending_row_request_table.sv @@
`timescale 1ns / 1ps
// one item at a time; a sweep reads the entry memory slot by slot, ST_RD then ST_EX per slot (N slots)
// add: count sweep, shift sweep, then insert; full table: count sweep only, then a full result
// reply releasing R entries: count sweep, one search per released thread, then an update sweep
// the entry memory has one write port and a registered read port
// rst_n is synchronous: clears the valid bits, the sequencer and the output valid flag; the
// entry memory and the other registers are not cleared
module pending_row_request_table #(
  parameter int TABLE_DEPTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  prt_in_if.sink    in_ch,
  prt_out_if.source out_ch
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]    tab;
    logic [19:0]   row;
    logic [30:0]   clock;
    logic [7:0]    thread;
    logic          sent;
    logic [IW-1:0] order;
  } entry_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_EX, ST_WNEW} state_t;
  typedef enum logic [1:0] {PH_COUNT, PH_SHIFT, PH_FIND, PH_UPDATE} phase_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic cmd_r, cmd_nxt;
  logic [7:0] tab_r, tab_nxt;
  logic [19:0] row_r, row_nxt;
  logic [30:0] clk_r, clk_nxt;
  logic [7:0] thr_r, thr_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic found_r, found_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic signed [31:0] nclk_r, nclk_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_thr_r, out_thr_nxt;
  logic out_send_r, out_send_nxt;
  logic signed [31:0] out_clk_r, out_clk_nxt;
  logic out_last_r, out_last_nxt;

  logic mem_we;
  logic [IW-1:0] mem_wa;
  entry_t mem_wd;

  logic hit, le, last_idx, out_free, found_c;
  logic [CW-1:0] cnt_c;
  logic [IW-1:0] free_c, idx_inc, new_order;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.released_thread = out_thr_r;
  assign out_ch.send_now = out_send_r;
  assign out_ch.req_clock = out_clk_r;
  assign out_ch.last = out_last_r;

  always_comb begin
    hit = valid_r[idx_r] && (rd_q.tab == tab_r) && (rd_q.row == row_r);
    le = (rd_q.clock <= clk_r);
    last_idx = (idx_r == IW'(TABLE_DEPTH - 1));
    idx_inc = last_idx ? '0 : idx_r + 1'b1;
    out_free = !out_valid_r || out_ch.ready;
    cnt_c = cnt_r + CW'(hit && le);
    found_c = found_r;
    free_c = free_r;
    if (cmd_r == prt_pkg::CMD_ADD && !valid_r[idx_r] && !found_r) begin
      found_c = 1'b1;
      free_c = idx_r;
    end
    new_order = rd_q.order - cnt_r[IW-1:0];

    st_nxt = st_r;
    ph_nxt = ph_r;
    valid_nxt = valid_r;
    cmd_nxt = cmd_r;
    tab_nxt = tab_r;
    row_nxt = row_r;
    clk_nxt = clk_r;
    thr_nxt = thr_r;
    idx_nxt = idx_r;
    free_nxt = free_r;
    found_nxt = found_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    nclk_nxt = nclk_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt = out_kind_r;
    out_thr_nxt = out_thr_r;
    out_send_nxt = out_send_r;
    out_clk_nxt = out_clk_r;
    out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = rd_q;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          tab_nxt = in_ch.tbl_id;
          row_nxt = in_ch.row_id;
          clk_nxt = in_ch.clock_req;
          thr_nxt = in_ch.thread_id;
          idx_nxt = '0;
          cnt_nxt = '0;
          found_nxt = 1'b0;
          ph_nxt = PH_COUNT;
          st_nxt = ST_RD;
        end
      end
      ST_RD: st_nxt = ST_EX;
      ST_EX: begin
        case (ph_r)
          PH_COUNT: begin
            if (!(last_idx && cmd_r == prt_pkg::CMD_ADD && !found_c && !out_free)) begin
              cnt_nxt = cnt_c;
              found_nxt = found_c;
              free_nxt = free_c;
              idx_nxt = idx_inc;
              st_nxt = ST_RD;
              if (last_idx) begin
                if (cmd_r == prt_pkg::CMD_ADD) begin
                  if (!found_c) begin
                    // no free slot: drop the add
                    out_valid_nxt = 1'b1;
                    out_kind_nxt = prt_pkg::KIND_FULL;
                    out_thr_nxt = '0;
                    out_send_nxt = 1'b0;
                    out_clk_nxt = '0;
                    out_last_nxt = 1'b1;
                    st_nxt = ST_IDLE;
                  end else begin
                    ph_nxt = PH_SHIFT;
                  end
                end else begin
                  k_nxt = '0;
                  nclk_nxt = prt_pkg::NO_CLOCK;
                  ph_nxt = (cnt_c == '0) ? PH_UPDATE : PH_FIND;
                end
              end
            end
          end
          PH_SHIFT: begin
            if (hit && CW'(rd_q.order) >= cnt_r) begin
              mem_we = 1'b1;
              mem_wd.order = rd_q.order + 1'b1;
            end
            idx_nxt = idx_inc;
            st_nxt = last_idx ? ST_WNEW : ST_RD;
          end
          PH_FIND: begin
            if (hit && CW'(rd_q.order) == k_r) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt = prt_pkg::KIND_REL;
                out_thr_nxt = rd_q.thread;
                out_send_nxt = 1'b0;
                out_clk_nxt = '0;
                out_last_nxt = 1'b0;
                k_nxt = k_r + 1'b1;
                idx_nxt = '0;
                if (k_r + 1'b1 == cnt_r) ph_nxt = PH_UPDATE;
                st_nxt = ST_RD;
              end
            end else begin
              idx_nxt = idx_inc;
              st_nxt = ST_RD;
            end
          end
          PH_UPDATE: begin
            // writes here are idempotent, so a stall on the last slot may repeat them
            if (hit) begin
              if (CW'(rd_q.order) < cnt_r) begin
                valid_nxt[idx_r] = 1'b0;
              end else begin
                mem_we = 1'b1;
                mem_wd.order = new_order;
                if (new_order == '0 && !rd_q.sent) begin
                  mem_wd.sent = 1'b1;
                  nclk_nxt = {1'b0, rd_q.clock};
                end
              end
            end
            if (!last_idx) begin
              idx_nxt = idx_inc;
              st_nxt = ST_RD;
            end else if (out_free) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt = prt_pkg::KIND_REPLY;
              out_thr_nxt = '0;
              out_send_nxt = 1'b0;
              out_clk_nxt = nclk_nxt;
              out_last_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_WNEW: begin
        if (out_free) begin
          mem_we = 1'b1;
          mem_wa = free_r;
          mem_wd.tab = tab_r;
          mem_wd.row = row_r;
          mem_wd.clock = clk_r;
          mem_wd.thread = thr_r;
          mem_wd.sent = (cnt_r == '0);
          mem_wd.order = cnt_r[IW-1:0];
          valid_nxt[free_r] = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt = prt_pkg::KIND_ADD;
          out_thr_nxt = '0;
          out_send_nxt = (cnt_r == '0);
          out_clk_nxt = '0;
          out_last_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (st_r == ST_RD) rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ph_r <= PH_COUNT;
      valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      valid_r <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    tab_r <= tab_nxt;
    row_r <= row_nxt;
    clk_r <= clk_nxt;
    thr_r <= thr_nxt;
    idx_r <= idx_nxt;
    free_r <= free_nxt;
    found_r <= found_nxt;
    cnt_r <= cnt_nxt;
    k_r <= k_nxt;
    nclk_r <= nclk_nxt;
    out_kind_r <= out_kind_nxt;
    out_thr_r <= out_thr_nxt;
    out_send_r <= out_send_nxt;
    out_clk_r <= out_clk_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ tb/prt_tb_if.sv @@
`timescale 1ns / 1ps
// the block's channel interfaces are compiled from sv/; this file holds the testbench-side types
package prt_tb_pkg;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  tbl_id;
    logic [19:0] row_id;
    logic [30:0] clock_req;
    logic [7:0]  thread_id;
  } row_req_t;

  typedef struct packed {
    prt_pkg::kind_t     kind;
    logic [7:0]         thread;
    logic               send_now;
    logic signed [31:0] req_clock;
    logic               last;
  } row_result_t;
endpackage

@@ tb/tb_pending_row_request_table.sv @@
`timescale 1ns / 1ps
module tb_pending_row_request_table;

  localparam int DEPTH = 32;
  localparam int EXP_SIZE = 16384;

  logic clk;
  logic rst_n;

  prt_in_if in_ch();
  prt_out_if out_ch();

  pending_row_request_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // shadow of the pending table
  logic        ent_valid [DEPTH];
  logic [7:0]  ent_table [DEPTH];
  logic [19:0] ent_row [DEPTH];
  logic [30:0] ent_clock [DEPTH];
  logic [7:0]  ent_thread [DEPTH];
  logic        ent_sent [DEPTH];
  int          ent_pos [DEPTH];

  // expected results, written by the predictor and consumed by the checker
  prt_tb_pkg::row_result_t exp_buf [EXP_SIZE];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int stall_mode = 0;
  int burst_left = 0;

  function automatic bit key_match(int i, logic [7:0] t, logic [19:0] r);
    return ent_valid[i] && ent_table[i] == t && ent_row[i] == r;
  endfunction

  function automatic prt_tb_pkg::row_result_t mk(prt_pkg::kind_t k, logic [7:0] th, logic s,
                                                 logic signed [31:0] c, logic l);
    prt_tb_pkg::row_result_t x;
    x.kind = k;
    x.thread = th;
    x.send_now = s;
    x.req_clock = c;
    x.last = l;
    return x;
  endfunction

  function automatic void exp_add(prt_tb_pkg::row_result_t x);
    if (exp_wr < EXP_SIZE) begin
      exp_buf[exp_wr] = x;
      exp_wr++;
    end
  endfunction

  task automatic predict_table(prt_tb_pkg::row_req_t q);
    int slot;
    int cnt;
    int k;
    int i;
    logic signed [31:0] nxt;
    slot = -1;
    cnt = 0;
    nxt = prt_pkg::NO_CLOCK;
    if (q.cmd == prt_pkg::CMD_ADD) begin
      for (i = 0; i < DEPTH; i++)
        if (!ent_valid[i] && slot < 0) slot = i;
      if (slot < 0) begin
        exp_add(mk(prt_pkg::KIND_FULL, 8'd0, 1'b0, 32'sd0, 1'b1));
        return;
      end
      for (i = 0; i < DEPTH; i++)
        if (key_match(i, q.tbl_id, q.row_id) && ent_clock[i] <= q.clock_req) cnt++;
      for (i = 0; i < DEPTH; i++)
        if (key_match(i, q.tbl_id, q.row_id) && ent_pos[i] >= cnt) ent_pos[i]++;
      ent_valid[slot] = 1'b1;
      ent_table[slot] = q.tbl_id;
      ent_row[slot] = q.row_id;
      ent_clock[slot] = q.clock_req;
      ent_thread[slot] = q.thread_id;
      ent_sent[slot] = (cnt == 0);
      ent_pos[slot] = cnt;
      exp_add(mk(prt_pkg::KIND_ADD, 8'd0, cnt == 0, 32'sd0, 1'b1));
    end else begin
      for (i = 0; i < DEPTH; i++)
        if (key_match(i, q.tbl_id, q.row_id) && ent_clock[i] <= q.clock_req) cnt++;
      for (k = 0; k < cnt; k++)
        for (i = 0; i < DEPTH; i++)
          if (key_match(i, q.tbl_id, q.row_id) && ent_pos[i] == k)
            exp_add(mk(prt_pkg::KIND_REL, ent_thread[i], 1'b0, 32'sd0, 1'b0));
      for (i = 0; i < DEPTH; i++)
        if (key_match(i, q.tbl_id, q.row_id)) begin
          if (ent_pos[i] < cnt) ent_valid[i] = 1'b0;
          else ent_pos[i] -= cnt;
        end
      for (i = 0; i < DEPTH; i++)
        if (key_match(i, q.tbl_id, q.row_id) && ent_pos[i] == 0) begin
          if (!ent_sent[i]) begin
            ent_sent[i] = 1'b1;
            nxt = {1'b0, ent_clock[i]};
          end
          break;
        end
      exp_add(mk(prt_pkg::KIND_REPLY, 8'd0, 1'b0, nxt, 1'b1));
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sends one item; items go out in bursts of random length with random gaps between
  task automatic send_req(logic c, logic [7:0] t, logic [19:0] r, logic [30:0] ck,
                          logic [7:0] th);
    prt_tb_pkg::row_req_t q;
    int gap;
    q.cmd = c;
    q.tbl_id = t;
    q.row_id = r;
    q.clock_req = ck;
    q.thread_id = th;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= q.cmd;
    in_ch.tbl_id <= q.tbl_id;
    in_ch.row_id <= q.row_id;
    in_ch.clock_req <= q.clock_req;
    in_ch.thread_id <= q.thread_id;
    do @(posedge clk); while (!in_ch.ready);
    predict_table(q);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (8 * DEPTH) @(negedge clk);
  endtask

  always @(posedge clk) begin
    prt_tb_pkg::row_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected transfer", 32'(out_ch.result_kind), 0);
      end else begin
        want = exp_buf[exp_rd];
        exp_rd++;
        if (out_ch.result_kind != want.kind)
          report_mismatch("result_kind", 32'(out_ch.result_kind), 32'(want.kind));
        if (out_ch.released_thread != want.thread)
          report_mismatch("released_thread", 32'(out_ch.released_thread), 32'(want.thread));
        if (out_ch.send_now != want.send_now)
          report_mismatch("send_now", 32'(out_ch.send_now), 32'(want.send_now));
        if (out_ch.req_clock != want.req_clock)
          report_mismatch("req_clock", out_ch.req_clock, want.req_clock);
        if (out_ch.last != want.last)
          report_mismatch("last", 32'(out_ch.last), 32'(want.last));
      end
    end
  end

  // receiver stall pattern: free-running, periodic, or random
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= (stall_cnt % 5) < 3;
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  task automatic test_edges();
    send_req(prt_pkg::CMD_REPLY, 8'd0, 20'd0, 31'd0, 8'd0);
    send_req(prt_pkg::CMD_ADD, 8'hFF, 20'hFFFFF, 31'h7FFFFFFF, 8'hFF);
    send_req(prt_pkg::CMD_ADD, 8'hFF, 20'hFFFFF, 31'd0, 8'h00);
    send_req(prt_pkg::CMD_ADD, 8'hFF, 20'hFFFFF, 31'd0, 8'h55);
    send_req(prt_pkg::CMD_ADD, 8'hFF, 20'hFFFFF, 31'd100, 8'hAA);
    send_req(prt_pkg::CMD_REPLY, 8'hFF, 20'hFFFFF, 31'd0, 8'hFF);
    send_req(prt_pkg::CMD_REPLY, 8'hFF, 20'hFFFFF, 31'd50, 8'd0);
    send_req(prt_pkg::CMD_REPLY, 8'hFF, 20'hFFFFF, 31'h7FFFFFFF, 8'd0);
    send_req(prt_pkg::CMD_REPLY, 8'hFF, 20'hFFFFF, 31'h7FFFFFFF, 8'd0);
  endtask

  task automatic test_table_full();
    int i;
    for (i = 0; i < DEPTH + 2; i++)
      send_req(prt_pkg::CMD_ADD, 8'h12, 20'h345, 31'(i % 4), 8'(i));
    drain_results();
    // release all of them in one reply
    send_req(prt_pkg::CMD_REPLY, 8'h12, 20'h345, 31'd3, 8'd0);
    drain_results();
  endtask

  task automatic test_random(int n);
    int i;
    logic [7:0] t;
    logic [19:0] r;
    logic [30:0] ck;
    int live;
    for (i = 0; i < n; i++) begin
      if (i % 70 == 0) stall_mode = (i / 70) % 3;
      // mostly a few hot keys so lists grow and merge
      if ($urandom_range(0, 9) < 8) begin
        t = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
        r = 20'($urandom_range(0, 2) == 0 ? 20'hFFFFF : $urandom_range(0, 1));
      end else begin
        t = 8'($urandom);
        r = 20'($urandom);
      end
      ck = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20));
      live = 0;
      foreach (ent_valid[j]) live += ent_valid[j];
      send_req(($urandom_range(0, 9) < (live > 24 ? 3 : 6)) ? prt_pkg::CMD_ADD
                                                             : prt_pkg::CMD_REPLY,
               t, r, ck, 8'($urandom));
      if (i == n / 2) drain_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = prt_pkg::CMD_ADD;
    in_ch.tbl_id = '0;
    in_ch.row_id = '0;
    in_ch.clock_req = '0;
    in_ch.thread_id = '0;
    foreach (ent_valid[i]) begin
      ent_valid[i] = 1'b0;
      ent_pos[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    stall_mode = 2;
    test_edges();
    drain_results();
    test_table_full();
    test_random(240);
    drain_results();
    if (errors == 0)
      $display("tb_pending_row_request_table passed");
    else
      $display("tb_pending_row_request_table failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_pending_row_request_table failed");
    $finish;
  end
endmodule
